// ----- rtl/sbt_pkg.sv -----
`timescale 1ns / 1ps
package sbt_pkg;

  localparam int MaxKeywordChars = 10;
  localparam int PositionBits = 16;
  localparam int MaxNestDepth = 255;
  localparam int KwCount = 24;
  localparam int QueueDepth = 4;

  typedef logic [PositionBits-1:0] pos_t;
  localparam pos_t PosMax = '1;

  typedef logic [$clog2(QueueDepth)-1:0] qptr_t;
  typedef logic [$clog2(QueueDepth+1)-1:0] qcnt_t;

  typedef enum logic [4:0] {
    M_NORMAL, M_SLASH, M_LINE, M_BLOCK, M_INT, M_DOT, M_FRAC, M_IDENT,
    M_STR, M_ESC, M_HASH, M_COLOR, M_MINUS, M_ASSIGN, M_BANG, M_LESS,
    M_GREATER
  } mode_t;

  localparam logic [5:0] K_END = 6'd0;
  localparam logic [5:0] K_ERROR = 6'd1;
  localparam logic [5:0] K_IDENT = 6'd2;
  localparam logic [5:0] K_INTEGER = 6'd3;
  localparam logic [5:0] K_FLOAT = 6'd4;
  localparam logic [5:0] K_STRBYTE = 6'd5;
  localparam logic [5:0] K_STREND = 6'd6;
  localparam logic [5:0] K_COLOR = 6'd7;
  localparam logic [5:0] K_KW0 = 6'd8;
  localparam logic [5:0] K_SINGLE0 = 6'd32;
  localparam logic [5:0] K_DOT = 6'd41;
  localparam logic [5:0] K_MINUS = 6'd43;
  localparam logic [5:0] K_SLASH = 6'd45;
  localparam logic [5:0] K_ARROW = 6'd47;
  localparam logic [5:0] K_ASSIGN = 6'd48;
  localparam logic [5:0] K_EQUAL = 6'd49;
  localparam logic [5:0] K_NOTEQ = 6'd50;
  localparam logic [5:0] K_LESS = 6'd51;
  localparam logic [5:0] K_LESSEQ = 6'd52;
  localparam logic [5:0] K_GREATER = 6'd53;
  localparam logic [5:0] K_GREATEREQ = 6'd54;
  localparam logic [5:0] K_HASH = 6'd55;

  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_UNEXPECTED = 3'd1;
  localparam logic [2:0] E_BANG = 3'd2;
  localparam logic [2:0] E_NEWLINE = 3'd3;
  localparam logic [2:0] E_ESC_END = 3'd4;
  localparam logic [2:0] E_BAD_ESC = 3'd5;
  localparam logic [2:0] E_UNTERM = 3'd6;
  localparam logic [2:0] E_COLOR = 3'd7;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic [31:0] value;
  } tok_t;

  // up to three tokens per byte and how many slots are in use
  typedef struct packed {
    logic [1:0] count;
    tok_t [2:0] tok;
  } group_t;

  typedef logic [MaxKeywordChars*8-1:0] kwbuf_t;

  function automatic logic [MaxKeywordChars*8-1:0] kw_text(input int k);
    case (k)
      0: kw_text = {8'd0, "retcarahc"};
      1: kw_text = "enecs";
      2: kw_text = "wohs";
      3: kw_text = "edih";
      4: kw_text = "yas";
      5: kw_text = "eciohc";
      6: kw_text = "fi";
      7: kw_text = "esle";
      8: kw_text = "otog";
      9: kw_text = "tiaw";
      10: kw_text = "yalp";
      11: kw_text = "pots";
      12: kw_text = "tes";
      13: kw_text = "eurt";
      14: kw_text = "eslaf";
      15: kw_text = "ta";
      16: kw_text = "dna";
      17: kw_text = "ro";
      18: kw_text = "ton";
      19: kw_text = "dnuorgkcab";
      20: kw_text = "cisum";
      21: kw_text = "dnuos";
      22: kw_text = "noitisnart";
      default: kw_text = "edaf";
    endcase
  endfunction

  function automatic logic [4:0] kw_len(input int k);
    case (k)
      0: kw_len = 5'd9;
      1, 14, 20, 21: kw_len = 5'd5;
      4, 12, 16, 18: kw_len = 5'd3;
      5: kw_len = 5'd6;
      6, 15, 17: kw_len = 5'd2;
      19, 22: kw_len = 5'd10;
      default: kw_len = 5'd4;
    endcase
  endfunction

  function automatic logic [15:0] sat16(input pos_t v);
    logic [31:0] w;
    w = 32'(v);
    sat16 = (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [15:0] inc_len(input logic [15:0] v);
    inc_len = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic pos_t inc_pos(input pos_t v);
    inc_pos = (v == PosMax) ? v : v + pos_t'(1);
  endfunction

endpackage

// ----- rtl/sbt_front.sv -----
`timescale 1ns / 1ps
module sbt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               in_end,
  output logic               in_ready,
  output logic               grp_valid,
  output sbt_pkg::group_t    grp,
  input  logic               grp_ready
);

  sbt_pkg::mode_t mode, mode_n;
  logic [7:0] depth, depth_n;
  logic [1:0] prev, prev_n;
  sbt_pkg::pos_t line, line_n, column, column_n, tcol, tcol_n, hcol, hcol_n;
  logic [15:0] len, len_n;
  logic [31:0] acc, acc_n;
  sbt_pkg::kwbuf_t ibuf, ibuf_n;
  sbt_pkg::group_t g;
  logic take;

  logic [7:0] b;
  logic dig, alp, idc, absorbed;
  logic [4:0] hv;
  logic [63:0] prod;
  logic [7:0] d;
  logic [5:0] ikind;
  sbt_pkg::pos_t nl;
  logic [15:0] l16, c16, t16, h16, n16;

  assign in_ready = !grp_valid || grp_ready;
  assign take = in_valid && in_ready;

  always_comb begin
    b = in_byte;
    dig = b inside {["0":"9"]};
    alp = b inside {["a":"z"], ["A":"Z"]};
    idc = alp || dig || b == "_";
    if (dig) hv = {1'b0, b[3:0]};
    else if (b inside {["a":"f"], ["A":"F"]}) hv = 5'(b[2:0]) + 5'd9;
    else hv = 5'd16;
    prod = {32'd0, acc} * 64'd10 + 64'(b - "0");
  end

  always_comb begin
    ikind = sbt_pkg::K_IDENT;
    for (int k = sbt_pkg::KwCount - 1; k >= 0; k--) begin
      if (16'(sbt_pkg::kw_len(k)) == len && 32'(sbt_pkg::kw_len(k)) <= sbt_pkg::MaxKeywordChars
          && (ibuf & ((sbt_pkg::kwbuf_t'(1) << (8 * sbt_pkg::kw_len(k))) - 1'b1))
             == sbt_pkg::kw_text(k))
        ikind = sbt_pkg::K_KW0 + 6'(k);
    end
  end

  always_comb begin
    mode_n = mode; depth_n = depth; prev_n = prev; line_n = line; column_n = column;
    tcol_n = tcol; hcol_n = hcol; len_n = len; acc_n = acc; ibuf_n = ibuf;
    g = '0;
    absorbed = 1'b0;
    d = 8'd0;
    nl = (b == 8'h0A) ? sbt_pkg::inc_pos(line) : line;
    l16 = sbt_pkg::sat16(line);
    c16 = sbt_pkg::sat16(column);
    t16 = sbt_pkg::sat16(tcol);
    h16 = sbt_pkg::sat16(hcol);
    n16 = len;

    if (!in_end) begin
      absorbed = 1'b0;
      case (mode)
        sbt_pkg::M_SLASH: begin
          if (b == "/") begin mode_n = sbt_pkg::M_LINE; absorbed = 1'b1; end
          else if (b == "*") begin
            mode_n = sbt_pkg::M_BLOCK; depth_n = 8'd1; prev_n = 2'd0; absorbed = 1'b1;
          end
        end
        sbt_pkg::M_LINE: begin
          if (b == 8'h0A) mode_n = sbt_pkg::M_NORMAL;
          else absorbed = 1'b1;
        end
        sbt_pkg::M_BLOCK: begin
          absorbed = 1'b1;
          if (prev == 2'd1 && b == "*") begin
            if (32'(depth) < sbt_pkg::MaxNestDepth) depth_n = depth + 8'd1;
            prev_n = 2'd0;
          end else if (prev == 2'd2 && b == "/") begin
            prev_n = 2'd0;
            if (depth != 0) depth_n = depth - 8'd1;
            if (depth <= 8'd1) mode_n = sbt_pkg::M_NORMAL;
          end else prev_n = (b == "/") ? 2'd1 : (b == "*") ? 2'd2 : 2'd0;
        end
        sbt_pkg::M_INT: begin
          if (dig) begin
            acc_n = (prod > 64'd2147483647) ? 32'd2147483647 : prod[31:0];
            len_n = sbt_pkg::inc_len(len); absorbed = 1'b1;
          end else if (b == ".") begin
            mode_n = sbt_pkg::M_DOT; hcol_n = column; absorbed = 1'b1;
          end
        end
        sbt_pkg::M_DOT: if (dig) begin
          mode_n = sbt_pkg::M_FRAC; len_n = sbt_pkg::inc_len(sbt_pkg::inc_len(len));
          absorbed = 1'b1;
        end
        sbt_pkg::M_FRAC: if (dig) begin len_n = sbt_pkg::inc_len(len); absorbed = 1'b1; end
        sbt_pkg::M_IDENT: if (idc) begin
          for (int i = 0; i < sbt_pkg::MaxKeywordChars; i++)
            if (32'(len) == i) ibuf_n[i*8 +: 8] = b;
          len_n = sbt_pkg::inc_len(len); absorbed = 1'b1;
        end
        sbt_pkg::M_STR: begin
          if (b == 8'h0A) begin
            g.count = 2'd1;
            g.tok[0] = '{sbt_pkg::K_ERROR, sbt_pkg::E_NEWLINE, l16, t16, len, 32'd0};
            mode_n = sbt_pkg::M_NORMAL;
          end else begin
            absorbed = 1'b1;
            len_n = sbt_pkg::inc_len(len);
            if (b == "\"") begin
              g.count = 2'd1;
              g.tok[0] = '{sbt_pkg::K_STREND, sbt_pkg::E_NONE, l16, t16, len_n, 32'd0};
              mode_n = sbt_pkg::M_NORMAL;
            end else if (b == "\\") begin
              mode_n = sbt_pkg::M_ESC; hcol_n = column;
            end else begin
              g.count = 2'd1;
              g.tok[0] = '{sbt_pkg::K_STRBYTE, sbt_pkg::E_NONE, l16, c16, 16'd1, 32'(b)};
            end
          end
        end
        sbt_pkg::M_ESC: begin
          absorbed = 1'b1;
          len_n = sbt_pkg::inc_len(len);
          g.count = 2'd1;
          case (b)
            "n": d = 8'd10;
            "r": d = 8'd13;
            "t": d = 8'd9;
            "\\", "\"": d = b;
            default: d = 8'd0;
          endcase
          if (d != 0) begin
            g.tok[0] = '{sbt_pkg::K_STRBYTE, sbt_pkg::E_NONE, l16, h16, 16'd2, 32'(d)};
            mode_n = sbt_pkg::M_STR;
          end else begin
            g.tok[0] = '{sbt_pkg::K_ERROR, sbt_pkg::E_BAD_ESC, sbt_pkg::sat16(nl), t16,
                         len_n, 32'd0};
            mode_n = sbt_pkg::M_NORMAL;
          end
        end
        sbt_pkg::M_HASH, sbt_pkg::M_COLOR: if (hv < 5'd16) begin
          mode_n = sbt_pkg::M_COLOR;
          acc_n = {acc[27:0], hv[3:0]};
          len_n = sbt_pkg::inc_len(len); absorbed = 1'b1;
        end
        sbt_pkg::M_MINUS, sbt_pkg::M_ASSIGN, sbt_pkg::M_BANG, sbt_pkg::M_LESS,
        sbt_pkg::M_GREATER: begin
          if (b == ((mode == sbt_pkg::M_MINUS) ? ">" : "=")) begin
            absorbed = 1'b1;
            g.count = 2'd1;
            g.tok[0] = '{sbt_pkg::K_ERROR, sbt_pkg::E_NONE, l16, t16, 16'd2, 32'd0};
            case (mode)
              sbt_pkg::M_MINUS: g.tok[0].kind = sbt_pkg::K_ARROW;
              sbt_pkg::M_ASSIGN: g.tok[0].kind = sbt_pkg::K_EQUAL;
              sbt_pkg::M_BANG: g.tok[0].kind = sbt_pkg::K_NOTEQ;
              sbt_pkg::M_LESS: g.tok[0].kind = sbt_pkg::K_LESSEQ;
              default: g.tok[0].kind = sbt_pkg::K_GREATEREQ;
            endcase
            mode_n = sbt_pkg::M_NORMAL;
          end
        end
        default: mode_n = sbt_pkg::M_NORMAL;
      endcase
    end

    if (in_end || !absorbed) begin
      // flush the pending token; g.count is 0 or 1 here (newline in string)
      case (mode)
        sbt_pkg::M_SLASH: begin
          g.tok[g.count] = '{sbt_pkg::K_SLASH, sbt_pkg::E_NONE, l16, t16, 16'd1, 32'd0};
          g.count++;
        end
        sbt_pkg::M_INT: begin
          g.tok[g.count] = '{sbt_pkg::K_INTEGER, sbt_pkg::E_NONE, l16, t16, n16, acc};
          g.count++;
        end
        sbt_pkg::M_DOT: begin
          g.tok[0] = '{sbt_pkg::K_INTEGER, sbt_pkg::E_NONE, l16, t16, n16, acc};
          g.tok[1] = '{sbt_pkg::K_DOT, sbt_pkg::E_NONE, l16, h16, 16'd1, 32'd0};
          g.count = 2'd2;
        end
        sbt_pkg::M_FRAC: begin
          g.tok[0] = '{sbt_pkg::K_FLOAT, sbt_pkg::E_NONE, l16, t16, n16, 32'd0};
          g.count = 2'd1;
        end
        sbt_pkg::M_IDENT: begin
          g.tok[0] = '{ikind, sbt_pkg::E_NONE, l16, t16, n16, 32'd0};
          g.count = 2'd1;
        end
        sbt_pkg::M_STR: if (in_end) begin
          g.tok[0] = '{sbt_pkg::K_ERROR, sbt_pkg::E_UNTERM, l16, t16, n16, 32'd0};
          g.count = 2'd1;
        end
        sbt_pkg::M_ESC: begin
          g.tok[0] = '{sbt_pkg::K_ERROR, sbt_pkg::E_ESC_END, l16, t16, n16, 32'd0};
          g.count = 2'd1;
        end
        sbt_pkg::M_HASH: begin
          g.tok[0] = '{sbt_pkg::K_HASH, sbt_pkg::E_NONE, l16, t16, 16'd1, 32'd0};
          g.count = 2'd1;
        end
        sbt_pkg::M_COLOR: begin
          if (n16 == 16'd4 || n16 == 16'd5 || n16 == 16'd7 || n16 == 16'd9)
            g.tok[0] = '{sbt_pkg::K_COLOR, sbt_pkg::E_NONE, l16, t16, n16, acc};
          else
            g.tok[0] = '{sbt_pkg::K_ERROR, sbt_pkg::E_COLOR, l16, t16, n16, 32'd0};
          g.count = 2'd1;
        end
        sbt_pkg::M_MINUS: begin
          g.tok[0] = '{sbt_pkg::K_MINUS, sbt_pkg::E_NONE, l16, t16, 16'd1, 32'd0};
          g.count = 2'd1;
        end
        sbt_pkg::M_ASSIGN: begin
          g.tok[0] = '{sbt_pkg::K_ASSIGN, sbt_pkg::E_NONE, l16, t16, 16'd1, 32'd0};
          g.count = 2'd1;
        end
        sbt_pkg::M_BANG: begin
          g.tok[0] = '{sbt_pkg::K_ERROR, sbt_pkg::E_BANG, l16, t16, 16'd1, 32'd0};
          g.count = 2'd1;
        end
        sbt_pkg::M_LESS: begin
          g.tok[0] = '{sbt_pkg::K_LESS, sbt_pkg::E_NONE, l16, t16, 16'd1, 32'd0};
          g.count = 2'd1;
        end
        sbt_pkg::M_GREATER: begin
          g.tok[0] = '{sbt_pkg::K_GREATER, sbt_pkg::E_NONE, l16, t16, 16'd1, 32'd0};
          g.count = 2'd1;
        end
        default: ;
      endcase

      if (in_end) begin
        g.tok[g.count] = '{sbt_pkg::K_END, sbt_pkg::E_NONE, l16, c16, 16'd0, 32'd0};
        g.count++;
        mode_n = sbt_pkg::M_NORMAL; depth_n = '0; prev_n = '0;
        line_n = sbt_pkg::pos_t'(1);
        column_n = sbt_pkg::pos_t'(1); tcol_n = sbt_pkg::pos_t'(1); len_n = '0; acc_n = '0;
        hcol_n = sbt_pkg::pos_t'(1);
      end else begin
        // start a new token with this byte
        mode_n = sbt_pkg::M_NORMAL;
        tcol_n = column; len_n = 16'd1; acc_n = '0;
        if (b inside {8'h20, 8'h0D, 8'h09, 8'h0A}) ;
        else if (b == "/") mode_n = sbt_pkg::M_SLASH;
        else if (dig) begin mode_n = sbt_pkg::M_INT; acc_n = 32'(b - "0"); end
        else if (alp || b == "_") begin mode_n = sbt_pkg::M_IDENT; ibuf_n[7:0] = b; end
        else if (b == "\"") mode_n = sbt_pkg::M_STR;
        else if (b == "#") mode_n = sbt_pkg::M_HASH;
        else if (b == "-") mode_n = sbt_pkg::M_MINUS;
        else if (b == "=") mode_n = sbt_pkg::M_ASSIGN;
        else if (b == "!") mode_n = sbt_pkg::M_BANG;
        else if (b == "<") mode_n = sbt_pkg::M_LESS;
        else if (b == ">") mode_n = sbt_pkg::M_GREATER;
        else begin
          g.tok[g.count] = '{sbt_pkg::K_ERROR, sbt_pkg::E_UNEXPECTED, l16, c16, 16'd1, 32'd0};
          case (b)
            "(": g.tok[g.count].kind = sbt_pkg::K_SINGLE0;
            ")": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd1;
            "{": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd2;
            "}": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd3;
            "[": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd4;
            "]": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd5;
            ",": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd6;
            ":": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd7;
            ";": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd8;
            ".": g.tok[g.count].kind = sbt_pkg::K_DOT;
            "+": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd10;
            "*": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd12;
            "%": g.tok[g.count].kind = sbt_pkg::K_SINGLE0 + 6'd14;
            default: ;
          endcase
          if (g.tok[g.count].kind != sbt_pkg::K_ERROR) g.tok[g.count].err = sbt_pkg::E_NONE;
          g.count++;
        end
      end
    end
    if (!in_end) begin
      line_n = nl;
      column_n = (b == 8'h0A) ? sbt_pkg::pos_t'(1) : sbt_pkg::inc_pos(column);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sbt_pkg::M_NORMAL; depth <= '0; prev <= '0; line <= sbt_pkg::pos_t'(1);
      column <= sbt_pkg::pos_t'(1); tcol <= sbt_pkg::pos_t'(1); hcol <= sbt_pkg::pos_t'(1);
      len <= '0; acc <= '0;
      grp_valid <= 1'b0;
    end else begin
      if (take) begin
        mode <= mode_n; depth <= depth_n; prev <= prev_n; line <= line_n;
        column <= column_n; tcol <= tcol_n; hcol <= hcol_n; len <= len_n; acc <= acc_n;
        grp_valid <= (g.count != 0);
      end else if (grp_ready) grp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ibuf <= ibuf_n;
      grp <= g;
    end
  end

endmodule

// ----- rtl/sbt_back.sv -----
`timescale 1ns / 1ps
// queue of token groups, serialised one token per cycle while out_ready is high
module sbt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             grp_valid,
  input  sbt_pkg::group_t  grp,
  output logic             grp_ready,
  output logic             out_valid,
  output sbt_pkg::tok_t    out_tok,
  output logic             out_last,
  input  logic             out_ready
);

  sbt_pkg::group_t q [sbt_pkg::QueueDepth];
  sbt_pkg::qptr_t wp, rp;
  sbt_pkg::qcnt_t cnt;
  logic [1:0] sub;
  logic push, pop;

  assign grp_ready = cnt < sbt_pkg::qcnt_t'(sbt_pkg::QueueDepth) || pop;
  assign push = grp_valid && grp_ready;
  assign out_valid = cnt != 0;
  assign out_tok = q[rp].tok[sub];
  assign out_last = (sub + 2'd1) == q[rp].count;
  assign pop = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (push) q[wp] <= grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; sub <= '0;
    end else begin
      if (push) wp <= wp + sbt_pkg::qptr_t'(1);
      if (pop) rp <= rp + sbt_pkg::qptr_t'(1);
      cnt <= cnt + sbt_pkg::qcnt_t'(push) - sbt_pkg::qcnt_t'(pop);
      if (out_valid && out_ready) sub <= out_last ? 2'd0 : sub + 2'd1;
    end
  end

endmodule

// ----- rtl/script_byte_tokenizer.sv -----
`timescale 1ns / 1ps
// Byte-stream tokenizer.
// s_axis: one source byte per item; tdata[7:0] = byte, tuser = end of source.
// m_axis: one token per item; tdata carries kind, error, line, column,
//   length and value; tlast marks the final token caused by one input item.
// A token passes the scanner's group register and then the queue.
// Throughput: one byte per cycle while the output drains; one byte can
//   release up to three tokens, which leave one per cycle from a
//   four-group queue between the scanner and the output side.
// When the receiver stalls the queue fills and s_axis_tready drops.
// The scanner's state (mode, accumulator, positions) is registered per byte.
// Reset returns to normal scanning at line 1, column 1 and empties the queue.
// End of source flushes the pending token, emits an END token, and returns
// the scanner to its reset state.
module script_byte_tokenizer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // source_byte
  input  logic         s_axis_tuser,   // end_of_source
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kind[5:0] error[8:6] line[24:9] column[40:25] length[56:41] value[88:57]
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tlast    // last_result
);

  logic grp_valid, grp_ready;
  sbt_pkg::group_t grp;
  sbt_pkg::tok_t tok;

  sbt_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_byte(s_axis_tdata),
    .in_end(s_axis_tuser), .in_ready(s_axis_tready),
    .grp_valid, .grp, .grp_ready
  );

  sbt_back u_back (
    .clk, .rst, .grp_valid, .grp, .grp_ready,
    .out_valid(m_axis_tvalid), .out_tok(tok), .out_last(m_axis_tlast),
    .out_ready(m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, tok.value, tok.len, tok.col, tok.line, tok.err, tok.kind};

endmodule

// ----- rtl/sbt_checker.sv -----
`timescale 1ns / 1ps
module sbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5:0] != sbt_pkg::K_ERROR |-> m_axis_tdata[8:6] == 3'd0)
    else $error("error code on non-error token");

  a_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5:0] == sbt_pkg::K_END |-> m_axis_tlast
      && m_axis_tdata[56:41] == 16'd0)
    else $error("end token malformed");

  a_line: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[24:9] != 16'd0)
    else $error("line zero");

  // an empty output side never holds off the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with nothing pending");

endmodule

bind script_byte_tokenizer sbt_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tlast
);

// ----- bench/script_byte_tokenizer_tb.sv -----
`timescale 1ns / 1ps
module script_byte_tokenizer_tb;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic [31:0] value;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tlast;

  script_byte_tokenizer dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #4 clk = ~clk;

  // lexer copy
  sbt_pkg::mode_t lx_mode;
  int unsigned lx_depth, lx_prev, lx_line, lx_colc, lx_tcol, lx_len, lx_acc, lx_held;
  logic [7:0]  lx_ident [sbt_pkg::MaxKeywordChars];
  token_t      step_toks [$];
  token_t      expected_tokens [$];

  int errors = 0;
  int tokens_seen = 0;
  int bytes_sent = 0;
  longint cycles = 0;
  bit hold_req = 1'b0;
  int hold_cycles = 0;

  string kw_words [sbt_pkg::KwCount] = '{"character", "scene", "show", "hide", "say",
    "choice", "if", "else", "goto", "wait", "play", "stop", "set", "true", "false", "at",
    "and", "or", "not", "background", "music", "sound", "transition", "fade"};

  function automatic bit is_dig(int unsigned b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic bit is_alp(int unsigned b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic int unsigned hexv(int unsigned b);
    if (is_dig(b)) return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return 16;
  endfunction
  function automatic int unsigned sat_add(int unsigned v);
    return v >= 65535 ? 65535 : v + 1;
  endfunction

  function automatic void add_tok(int unsigned k, int unsigned e, int unsigned ln,
                                  int unsigned c, int unsigned n, int unsigned v);
    token_t t;
    if (step_toks.size() >= 4) return;
    t.kind = k[5:0]; t.err = e[2:0];
    t.line = ln > 65535 ? 16'hFFFF : ln[15:0];
    t.col = c > 65535 ? 16'hFFFF : c[15:0];
    t.len = n > 65535 ? 16'hFFFF : n[15:0];
    t.value = v; t.last = 1'b0;
    step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic int unsigned word_kind();
    int unsigned i, j;
    bit ok;
    for (i = 0; i < sbt_pkg::KwCount; i++) begin
      if (kw_words[i].len() == lx_len && lx_len <= sbt_pkg::MaxKeywordChars) begin
        ok = 1'b1;
        for (j = 0; j < lx_len; j++) if (lx_ident[j] != kw_words[i][j]) ok = 1'b0;
        if (ok) return sbt_pkg::K_KW0 + i;
      end
    end
    return sbt_pkg::K_IDENT;
  endfunction

  function automatic void lex_reset();
    lx_mode = sbt_pkg::M_NORMAL; lx_depth = 0; lx_prev = 0; lx_line = 1; lx_colc = 1;
    lx_tcol = 1; lx_len = 0; lx_acc = 0; lx_held = 1;
    foreach (lx_ident[i]) lx_ident[i] = 8'd0;
  endfunction

  function automatic void flush_token(int unsigned ln);
    int unsigned c, n;
    c = lx_tcol; n = lx_len;
    case (lx_mode)
      sbt_pkg::M_SLASH: add_tok(sbt_pkg::K_SLASH, 0, ln, c, 1, 0);
      sbt_pkg::M_INT: add_tok(sbt_pkg::K_INTEGER, 0, ln, c, n, lx_acc);
      sbt_pkg::M_DOT: begin
        add_tok(sbt_pkg::K_INTEGER, 0, ln, c, n, lx_acc);
        add_tok(sbt_pkg::K_DOT, 0, ln, lx_held, 1, 0);
      end
      sbt_pkg::M_FRAC: add_tok(sbt_pkg::K_FLOAT, 0, ln, c, n, 0);
      sbt_pkg::M_IDENT: add_tok(word_kind(), 0, ln, c, n, 0);
      sbt_pkg::M_STR: add_tok(sbt_pkg::K_ERROR, sbt_pkg::E_UNTERM, ln, c, n, 0);
      sbt_pkg::M_ESC: add_tok(sbt_pkg::K_ERROR, sbt_pkg::E_ESC_END, ln, c, n, 0);
      sbt_pkg::M_HASH: add_tok(sbt_pkg::K_HASH, 0, ln, c, 1, 0);
      sbt_pkg::M_COLOR: begin
        if (n == 4 || n == 5 || n == 7 || n == 9)
          add_tok(sbt_pkg::K_COLOR, 0, ln, c, n, lx_acc);
        else add_tok(sbt_pkg::K_ERROR, sbt_pkg::E_COLOR, ln, c, n, 0);
      end
      sbt_pkg::M_MINUS: add_tok(sbt_pkg::K_MINUS, 0, ln, c, 1, 0);
      sbt_pkg::M_ASSIGN: add_tok(sbt_pkg::K_ASSIGN, 0, ln, c, 1, 0);
      sbt_pkg::M_BANG: add_tok(sbt_pkg::K_ERROR, sbt_pkg::E_BANG, ln, c, 1, 0);
      sbt_pkg::M_LESS: add_tok(sbt_pkg::K_LESS, 0, ln, c, 1, 0);
      sbt_pkg::M_GREATER: add_tok(sbt_pkg::K_GREATER, 0, ln, c, 1, 0);
      default: ;
    endcase
    lx_mode = sbt_pkg::M_NORMAL;
  endfunction

  function automatic void begin_token(int unsigned b, int unsigned ln, int unsigned cl);
    string singles;
    int unsigned i;
    singles = "(){}[],:;.+-*/%";
    lx_mode = sbt_pkg::M_NORMAL; lx_tcol = cl; lx_len = 1; lx_acc = 0;
    if (b == " " || b == 13 || b == 9 || b == 10) return;
    if (b == "/") begin lx_mode = sbt_pkg::M_SLASH; return; end
    if (is_dig(b)) begin lx_mode = sbt_pkg::M_INT; lx_acc = b - "0"; return; end
    if (is_alp(b) || b == "_") begin
      lx_mode = sbt_pkg::M_IDENT; lx_ident[0] = b[7:0]; return;
    end
    case (b)
      "\"": begin lx_mode = sbt_pkg::M_STR; return; end
      "#": begin lx_mode = sbt_pkg::M_HASH; return; end
      "-": begin lx_mode = sbt_pkg::M_MINUS; return; end
      "=": begin lx_mode = sbt_pkg::M_ASSIGN; return; end
      "!": begin lx_mode = sbt_pkg::M_BANG; return; end
      "<": begin lx_mode = sbt_pkg::M_LESS; return; end
      ">": begin lx_mode = sbt_pkg::M_GREATER; return; end
      default: ;
    endcase
    for (i = 0; i < 15; i++)
      if (singles[i] == b) begin add_tok(sbt_pkg::K_SINGLE0 + i, 0, ln, cl, 1, 0); return; end
    add_tok(sbt_pkg::K_ERROR, sbt_pkg::E_UNEXPECTED, ln, cl, 1, 0);
  endfunction

  function automatic bit continue_token(int unsigned b, int unsigned ln, int unsigned nl,
                                        int unsigned cl);
    int unsigned d;
    longint unsigned v;
    case (lx_mode)
      sbt_pkg::M_SLASH: begin
        if (b == "/") begin lx_mode = sbt_pkg::M_LINE; return 1; end
        if (b == "*") begin
          lx_mode = sbt_pkg::M_BLOCK; lx_depth = 1; lx_prev = 0; return 1;
        end
        return 0;
      end
      sbt_pkg::M_LINE: begin
        if (b == 10) begin lx_mode = sbt_pkg::M_NORMAL; return 0; end
        return 1;
      end
      sbt_pkg::M_BLOCK: begin
        if (lx_prev == 1 && b == "*") begin
          if (lx_depth < sbt_pkg::MaxNestDepth) lx_depth++;
          lx_prev = 0;
        end else if (lx_prev == 2 && b == "/") begin
          lx_prev = 0;
          if (lx_depth > 0) lx_depth--;
          if (lx_depth == 0) lx_mode = sbt_pkg::M_NORMAL;
        end else lx_prev = b == "/" ? 1 : (b == "*" ? 2 : 0);
        return 1;
      end
      sbt_pkg::M_INT: begin
        if (is_dig(b)) begin
          v = longint'(lx_acc) * 10 + (b - "0");
          lx_acc = v > 64'd2147483647 ? 32'd2147483647 : 32'(v);
          lx_len = sat_add(lx_len);
          return 1;
        end
        if (b == ".") begin lx_mode = sbt_pkg::M_DOT; lx_held = cl; return 1; end
        return 0;
      end
      sbt_pkg::M_DOT: begin
        if (!is_dig(b)) return 0;
        lx_mode = sbt_pkg::M_FRAC; lx_len = sat_add(sat_add(lx_len));
        return 1;
      end
      sbt_pkg::M_FRAC, sbt_pkg::M_IDENT: begin
        if (lx_mode == sbt_pkg::M_FRAC ? !is_dig(b) : !(is_alp(b) || is_dig(b) || b == "_"))
          return 0;
        if (lx_mode == sbt_pkg::M_IDENT && lx_len < sbt_pkg::MaxKeywordChars)
          lx_ident[lx_len] = b[7:0];
        lx_len = sat_add(lx_len);
        return 1;
      end
      sbt_pkg::M_STR: begin
        if (b == 10) begin
          add_tok(sbt_pkg::K_ERROR, sbt_pkg::E_NEWLINE, ln, lx_tcol, lx_len, 0);
          lx_mode = sbt_pkg::M_NORMAL;
          return 0;
        end
        lx_len = sat_add(lx_len);
        if (b == "\"") begin
          add_tok(sbt_pkg::K_STREND, 0, ln, lx_tcol, lx_len, 0);
          lx_mode = sbt_pkg::M_NORMAL;
        end else if (b == "\\") begin
          lx_mode = sbt_pkg::M_ESC; lx_held = cl;
        end else add_tok(sbt_pkg::K_STRBYTE, 0, ln, cl, 1, b);
        return 1;
      end
      sbt_pkg::M_ESC: begin
        lx_len = sat_add(lx_len);
        d = b == "n" ? 10 : b == "r" ? 13 : b == "t" ? 9 :
            (b == "\\" || b == "\"") ? b : 256;
        if (d < 256) begin
          add_tok(sbt_pkg::K_STRBYTE, 0, ln, lx_held, 2, d);
          lx_mode = sbt_pkg::M_STR;
        end else begin
          add_tok(sbt_pkg::K_ERROR, sbt_pkg::E_BAD_ESC, nl, lx_tcol, lx_len, 0);
          lx_mode = sbt_pkg::M_NORMAL;
        end
        return 1;
      end
      sbt_pkg::M_HASH, sbt_pkg::M_COLOR: begin
        d = hexv(b);
        if (d >= 16) return 0;
        lx_mode = sbt_pkg::M_COLOR; lx_acc = (lx_acc << 4) | d; lx_len = sat_add(lx_len);
        return 1;
      end
      sbt_pkg::M_MINUS, sbt_pkg::M_ASSIGN, sbt_pkg::M_BANG, sbt_pkg::M_LESS,
      sbt_pkg::M_GREATER: begin
        d = lx_mode == sbt_pkg::M_MINUS ? ">" : "=";
        if (b != d) return 0;
        d = lx_mode == sbt_pkg::M_MINUS ? sbt_pkg::K_ARROW :
            lx_mode == sbt_pkg::M_ASSIGN ? sbt_pkg::K_EQUAL :
            lx_mode == sbt_pkg::M_BANG ? sbt_pkg::K_NOTEQ :
            lx_mode == sbt_pkg::M_LESS ? sbt_pkg::K_LESSEQ : sbt_pkg::K_GREATEREQ;
        add_tok(d, 0, ln, lx_tcol, 2, 0);
        lx_mode = sbt_pkg::M_NORMAL;
        return 1;
      end
      default: begin
        lx_mode = sbt_pkg::M_NORMAL;
        return 0;
      end
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] byte_in, logic eos);
    int unsigned b, ln, cl, nl;
    b = byte_in; ln = lx_line; cl = lx_colc;
    nl = (b == 10) ? (ln >= 65535 ? 65535 : ln + 1) : ln;
    step_toks.delete();
    if (eos) begin
      flush_token(ln);
      add_tok(sbt_pkg::K_END, 0, ln, cl, 0, 0);
      lex_reset();
    end else begin
      if (!continue_token(b, ln, nl, cl)) begin
        flush_token(ln);
        begin_token(b, ln, cl);
      end
      lx_line = nl;
      lx_colc = (b == 10) ? 1 : (cl >= 65535 ? 65535 : cl + 1);
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.insert(expected_tokens.size(), step_toks[i]);
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("ERROR token %0d: %s", tokens_seen, what);
  endtask

  // send one byte; the lexer copy advances at acceptance, valid stays up
  // for a following item with no gap
  task automatic send_byte(logic [7:0] b, logic eos = 1'b0, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= eos;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_tokens(b, eos);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("script_byte_tokenizer: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req && hold_cycles < 60) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      if (!hold_req) hold_cycles <= 0;
      if ($urandom_range(0, 3) == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 10) < 5);
    end
  end

  always @(posedge clk) begin
    token_t got, exp_t;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tdata[5:0]; got.err = m_axis_tdata[8:6];
      got.line = m_axis_tdata[24:9]; got.col = m_axis_tdata[40:25];
      got.len = m_axis_tdata[56:41]; got.value = m_axis_tdata[88:57];
      got.last = m_axis_tlast;
      if (expected_tokens.size() == 0) report_mismatch("token with none expected");
      else begin
        exp_t = expected_tokens.pop_front();
        if (got.kind != exp_t.kind)
          report_mismatch($sformatf("kind %0d want %0d", got.kind, exp_t.kind));
        if (got.err != exp_t.err)
          report_mismatch($sformatf("error %0d want %0d", got.err, exp_t.err));
        if (got.line != exp_t.line)
          report_mismatch($sformatf("line %0d want %0d", got.line, exp_t.line));
        if (got.col != exp_t.col)
          report_mismatch($sformatf("column %0d want %0d", got.col, exp_t.col));
        if (got.len != exp_t.len)
          report_mismatch($sformatf("length %0d want %0d", got.len, exp_t.len));
        if (got.value != exp_t.value)
          report_mismatch($sformatf("value %0h want %0h", got.value, exp_t.value));
        if (got.last != exp_t.last)
          report_mismatch($sformatf("last %0b want %0b", got.last, exp_t.last));
      end
      tokens_seen++;
    end
  end

  task automatic test_operators_and_keywords();
    send_text("if(x<=12)->a!=b>=c==d\"q\\n\\x\"#1a2B3c4d#12 9.5 1.z\xff!");
    send_byte(8'h00);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_edge_cases();
    send_text("99999999999 /*a/*b*/c*/ backgrounds \"ab\n#12345");
    send_byte(8'h22); send_byte(8'h5c);
    send_byte(8'h00, 1'b1);
    send_text("\"s\\");
    send_byte(8'h0a); send_text("// x\n/* open");
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_byte((i % 2) ? ";" : ",", 1'b0, 1'b1);
    hold_req = 1'b0;
    drain();
  endtask

  task automatic test_random_scripts();
    string frags [20] = '{"show ", "scene ", "transition", "fade(", "x_1 ", "123", "4.25",
      "\"hi\\t\"", "#fff ", "#abcdef12", "->", "<", ">", "=", "!", "/* c */", "// c\n",
      "\n", " ", "character "};
    int sent;
    sent = 0;
    while (sent < 30) begin
      if ($urandom_range(0, 4) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0); sent++;
      end else begin
        string f;
        f = frags[$urandom_range(0, 19)];
        send_text(f); sent += f.len();
      end
      if ($urandom_range(0, 40) == 0) begin send_byte(8'h00, 1'b1); sent++; end
    end
    send_byte(8'h00, 1'b1);
  endtask

  initial begin
    lex_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_operators_and_keywords();
    drain();
    test_edge_cases();
    test_backpressure();
    test_random_scripts();
    drain();
    $display("Covered %0d bytes and %0d tokens: operators, keywords, numbers,", bytes_sent,
             tokens_seen);
    $display("strings, colours, comments, errors, end of source and back-pressure.");
    if (errors == 0) $display("script_byte_tokenizer: match");
    else $display("script_byte_tokenizer: mismatch");
    $finish;
  end
endmodule
